// ----- rtl/mtee_pkg.sv -----
// ----------------------------------------------------------------------------
// mtee_pkg
// Shared types, codes and helpers of the MIDI track event encoder.
// ----------------------------------------------------------------------------
package mtee_pkg;

  typedef enum logic [2:0] {
    CMD_SHORT    = 3'd0,
    CMD_SYSEX    = 3'd1,
    CMD_META     = 3'd2,
    CMD_PAYLOAD  = 3'd3,
    CMD_NEWTRACK = 3'd4
  } cmd_t;

  localparam logic [7:0]  SYSEX_ESC  = 8'hF7;
  localparam logic [7:0]  META_MARK  = 8'hFF;
  localparam logic [27:0] VLQ_MAX    = 28'h0FFFFFFF;
  // (VLQ_MAX + 1) * 1000 us: at or above this the delta saturates
  localparam logic [47:0] SAT_US     = 48'd268435456000;
  // divide by 1000 as a shift by 3 and a multiply by 2^42 / 125 rounded up,
  // exact for every shifted difference below SAT_US
  localparam logic [17:0] RCP_HI     = 18'h20C49;
  localparam logic [17:0] RCP_LO     = 18'h2E979;
  localparam logic [2:0]  DIV_CYC    = 3'd3;

  // one queued event, delta already in milliseconds
  typedef struct packed {
    cmd_t        cmd;
    logic [27:0] ms;
    logic [7:0]  status;
    logic [7:0]  data_first;
    logic [7:0]  data_second;
    logic [15:0] count;
    logic [7:0]  payload_byte;
  } evt_t;

  // variable-length quantity, bytes left aligned
  typedef struct packed {
    logic [31:0] bytes;
    logic [2:0]  len;
  } vlq_t;

  function automatic vlq_t vlq_enc(input logic [27:0] v);
    vlq_t r;
    if (v[27:21] != 7'd0) begin
      r.len   = 3'd4;
      r.bytes = {1'b1, v[27:21], 1'b1, v[20:14], 1'b1, v[13:7], 1'b0, v[6:0]};
    end else if (v[20:14] != 7'd0) begin
      r.len   = 3'd3;
      r.bytes = {1'b1, v[20:14], 1'b1, v[13:7], 1'b0, v[6:0], 8'h00};
    end else if (v[13:7] != 7'd0) begin
      r.len   = 3'd2;
      r.bytes = {1'b1, v[13:7], 1'b0, v[6:0], 16'h0000};
    end else begin
      r.len   = 3'd1;
      r.bytes = {1'b0, v[6:0], 24'h000000};
    end
    return r;
  endfunction

endpackage

// ----- rtl/mtee_front.sv -----
// ----------------------------------------------------------------------------
// mtee_front
// Accepts requests, drops unknown commands, turns timestamps into
// millisecond deltas and hands events to the queue.
// ----------------------------------------------------------------------------
module mtee_front import mtee_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [47:0] in_time_us,
  input  logic [7:0]  in_status,
  input  logic [7:0]  in_data_first,
  input  logic [7:0]  in_data_second,
  input  logic [15:0] in_count,
  input  logic [7:0]  in_payload_byte,
  output logic        q_push,
  output evt_t        q_data,
  input  logic        q_full
);

  typedef enum logic [3:0] {
    F_EMPTY = 4'b0001,
    F_LOAD  = 4'b0010,
    F_DIV   = 4'b0100,
    F_FULL  = 4'b1000
  } fstate_t;

  fstate_t     st_r, st_nxt;
  logic [2:0]  cyc_r, cyc_nxt;
  logic [47:0] prev_r, prev_nxt;
  logic [47:0] diff_r, diff_nxt;
  logic        bw_r, bw_nxt;
  logic [34:0] dvd_r, dvd_nxt;
  logic [70:0] prod_r, prod_nxt;
  evt_t        ent_r, ent_nxt;
  logic [48:0] sub;
  logic        acc;
  logic [17:0] xs;
  logic [35:0] pp_lo, pp_hi;
  logic [53:0] part;

  assign q_push   = (st_r == F_FULL) && !q_full;
  assign in_stall = (st_r != F_EMPTY) && !q_push;
  assign acc      = in_valid && !in_stall;
  assign sub      = {1'b0, in_time_us} - {1'b0, prev_r};

  // quotient by 125 is (x * reciprocal) >> 42: low half of x, then high half
  assign xs    = (cyc_r == DIV_CYC) ? {1'b0, dvd_r[16:0]} : dvd_r[34:17];
  assign pp_lo = xs * RCP_LO;
  assign pp_hi = xs * RCP_HI;
  assign part  = {pp_hi, 18'd0} + {18'd0, pp_lo};

  always_comb begin
    q_data    = ent_r;
    q_data.ms = dvd_r[27:0];
  end

  always_comb begin
    st_nxt   = st_r;
    cyc_nxt  = cyc_r;
    prev_nxt = prev_r;
    diff_nxt = diff_r;
    bw_nxt   = bw_r;
    dvd_nxt  = dvd_r;
    prod_nxt = prod_r;
    ent_nxt  = ent_r;
    case (st_r)
      F_LOAD: begin
        if (bw_r) begin
          dvd_nxt = '0;
          st_nxt  = F_FULL;
        end else if (diff_r >= SAT_US) begin
          dvd_nxt = {7'd0, VLQ_MAX};
          st_nxt  = F_FULL;
        end else begin
          dvd_nxt = diff_r[37:3];
          cyc_nxt = DIV_CYC;
          st_nxt  = F_DIV;
        end
      end
      F_DIV: begin
        cyc_nxt = cyc_r - 3'd1;
        if (cyc_r == DIV_CYC) begin
          prod_nxt = {17'd0, part};
        end else if (cyc_r == 3'd1) begin
          dvd_nxt = {7'd0, prod_r[69:42]};
          st_nxt  = F_FULL;
        end else begin
          prod_nxt = prod_r + {part, 17'd0};
        end
      end
      F_FULL: begin
        if (q_push) begin
          st_nxt = F_EMPTY;
        end
      end
      default: begin
        st_nxt = st_r;
      end
    endcase
    if (acc) begin
      ent_nxt.cmd          = cmd_t'(in_cmd);
      ent_nxt.ms           = '0;
      ent_nxt.status       = in_status;
      ent_nxt.data_first   = in_data_first;
      ent_nxt.data_second  = in_data_second;
      ent_nxt.count        = in_count;
      ent_nxt.payload_byte = in_payload_byte;
      case (cmd_t'(in_cmd))
        CMD_SHORT, CMD_SYSEX, CMD_META: begin
          prev_nxt = in_time_us;
          diff_nxt = sub[47:0];
          bw_nxt   = sub[48];
          st_nxt   = F_LOAD;
        end
        CMD_PAYLOAD: begin
          st_nxt = F_FULL;
        end
        CMD_NEWTRACK: begin
          prev_nxt = '0;
          st_nxt   = F_FULL;
        end
        default: begin
          // unknown command: nothing queued
          st_nxt = F_EMPTY;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= F_EMPTY;
      prev_r <= '0;
      cyc_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      prev_r <= prev_nxt;
      cyc_r  <= cyc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    diff_r <= diff_nxt;
    bw_r   <= bw_nxt;
    dvd_r  <= dvd_nxt;
    prod_r <= prod_nxt;
    ent_r  <= ent_nxt;
  end

endmodule

// ----- rtl/mtee_fifo.sv -----
// ----------------------------------------------------------------------------
// mtee_fifo
// Short event queue between the front and the byte sequencer.
// ----------------------------------------------------------------------------
module mtee_fifo import mtee_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  evt_t push_data,
  output logic full,
  input  logic pop,
  output logic avail,
  output evt_t pop_data
);

  localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  evt_t          ents_r [DEPTH];
  logic [AW-1:0] wr_r, wr_nxt;
  logic [AW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == CW'(DEPTH));
  assign avail    = (cnt_r != '0);
  assign pop_data = ents_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + AW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ents_r[wr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/mtee_back.sv -----
// ----------------------------------------------------------------------------
// mtee_back
// Expands one queued event into track bytes, keeps the track byte count
// and drives the output register.
// ----------------------------------------------------------------------------
module mtee_back import mtee_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_avail,
  input  evt_t        q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic [31:0] out_track_bytes
);

  logic [71:0] buf_r, buf_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [31:0] tl_r, tl_nxt;
  logic        ov_r, ov_nxt;
  logic [7:0]  ob_r, ob_nxt;
  logic        ol_r, ol_nxt;
  logic [31:0] otb_r, otb_nxt;
  logic        issue;
  vlq_t        vd, vc;
  logic [31:0] a_bytes;
  logic [2:0]  la;
  logic [39:0] rest;
  logic [2:0]  lb;

  assign q_pop = q_avail && (cnt_r == 4'd0);
  assign issue = (cnt_r != 4'd0) && (!ov_r || !out_stall);

  assign out_valid       = ov_r;
  assign out_byte        = ob_r;
  assign out_last        = ol_r;
  assign out_track_bytes = otb_r;

  // byte image of the event at the head of the queue
  always_comb begin
    // first event of a track gets a zero delta
    vd      = vlq_enc((tl_r == 32'd0) ? 28'd0 : q_data.ms);
    vc      = vlq_enc({12'd0, q_data.count});
    a_bytes = vd.bytes;
    la      = vd.len;
    rest    = '0;
    lb      = 3'd0;
    case (q_data.cmd)
      CMD_SHORT: begin
        rest = {q_data.status, q_data.data_first, q_data.data_second, 16'h0000};
        if (q_data.count == 16'd0) begin
          lb = 3'd1;
        end else if (q_data.count == 16'd1) begin
          lb = 3'd2;
        end else begin
          lb = 3'd3;
        end
      end
      CMD_SYSEX: begin
        rest = {SYSEX_ESC, vc.bytes};
        lb   = 3'd1 + vc.len;
      end
      CMD_META: begin
        rest = {META_MARK, q_data.data_first, vc.bytes[31:8]};
        lb   = 3'd2 + vc.len;
      end
      CMD_PAYLOAD: begin
        a_bytes = '0;
        la      = 3'd0;
        rest    = {q_data.payload_byte, 32'h00000000};
        lb      = 3'd1;
      end
      default: begin
        a_bytes = '0;
        la      = 3'd0;
      end
    endcase
  end

  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    tl_nxt  = tl_r;
    ov_nxt  = ov_r;
    ob_nxt  = ob_r;
    ol_nxt  = ol_r;
    otb_nxt = otb_r;
    if (q_pop) begin
      buf_nxt = {a_bytes, 40'h0} | ({rest, 32'h0} >> {la, 3'b000});
      cnt_nxt = {1'b0, la} + {1'b0, lb};
      if (q_data.cmd == CMD_NEWTRACK) begin
        tl_nxt = '0;
      end
    end
    if (issue) begin
      ov_nxt  = 1'b1;
      ob_nxt  = buf_r[71:64];
      ol_nxt  = (cnt_r == 4'd1);
      otb_nxt = tl_r + 32'd1;
      tl_nxt  = tl_r + 32'd1;
      buf_nxt = {buf_r[63:0], 8'h00};
      cnt_nxt = cnt_r - 4'd1;
    end else if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      tl_r  <= '0;
      ov_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      tl_r  <= tl_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    ob_r  <= ob_nxt;
    ol_r  <= ol_nxt;
    otb_r <= otb_nxt;
  end

endmodule

// ----- rtl/midi_track_event_encoder.sv -----
// ----------------------------------------------------------------------------
// midi_track_event_encoder
// Encodes timestamped MIDI events as Standard MIDI File track bytes.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  in      | in_valid / in_stall     | cmd, time_us, status, data bytes, count,
//          |                         | payload_byte
//  out     | out_valid / out_stall   | out_byte, out_last, out_track_bytes
//
// front: a timed event is subtracted when taken, range checked, then multiplied by
// the reciprocal of 125 in two halves; the multiply is skipped when the time goes
// backward or the delta saturates; other requests go straight to the queue.
// back: one track byte per cycle while the output is not stalled; the next request
// is fetched only once every byte of the last one has left; the slower side sets the rate.
// reset is synchronous and clears the control state, previous time and
// track length; out_stall holds the output register and the queue lets the
// front keep taking requests until it fills.
// ----------------------------------------------------------------------------
module midi_track_event_encoder import mtee_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [47:0] in_time_us,
  input  logic [7:0]  in_status,
  input  logic [7:0]  in_data_first,
  input  logic [7:0]  in_data_second,
  input  logic [15:0] in_count,
  input  logic [7:0]  in_payload_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic [31:0] out_track_bytes
);

  logic q_push, q_full, q_pop, q_avail;
  evt_t q_in, q_out;

  mtee_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_time_us      (in_time_us),
    .in_status       (in_status),
    .in_data_first   (in_data_first),
    .in_data_second  (in_data_second),
    .in_count        (in_count),
    .in_payload_byte (in_payload_byte),
    .q_push          (q_push),
    .q_data          (q_in),
    .q_full          (q_full)
  );

  mtee_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .pop_data  (q_out)
  );

  mtee_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_avail         (q_avail),
    .q_data          (q_out),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last        (out_last),
    .out_track_bytes (out_track_bytes)
  );

endmodule

// ----- rtl/mtee_checker.sv -----
// ----------------------------------------------------------------------------
// mtee_checker
// Port-level checks of the MIDI track event encoder, bound to the top level.
// ----------------------------------------------------------------------------
module mtee_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic        out_last,
  input logic [31:0] out_track_bytes
);

  // nothing is shown in the cycle after a reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // bytes of one request come out back to back with a rising count
  a_burst_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=>
      out_valid && (out_track_bytes == $past(out_track_bytes) + 32'd1))
    else $error("track byte count or burst broken");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_byte) && $stable(out_last) && $stable(out_track_bytes))
    else $error("stalled output changed");

endmodule

bind midi_track_event_encoder mtee_checker u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_byte        (out_byte),
  .out_last        (out_last),
  .out_track_bytes (out_track_bytes)
);

// ----- tb/sv/mtee_track_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mtee_track_checker
// Watches both channels of the MIDI track event encoder. Every accepted
// request is run through an in-house model of the track encoding and the
// resulting bytes are queued; each accepted output byte is compared field by
// field against the oldest queued byte.
// ----------------------------------------------------------------------------
module mtee_track_checker
  import mtee_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [47:0] in_time_us,
  input  logic [7:0]  in_status,
  input  logic [7:0]  in_data_first,
  input  logic [7:0]  in_data_second,
  input  logic [15:0] in_count,
  input  logic [7:0]  in_payload_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic        out_last,
  input  logic [31:0] out_track_bytes,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [7:0]  value;
    logic        last;
    logic [31:0] total;
  } track_byte_t;

  track_byte_t track_q[$];
  logic [47:0] stamp;
  logic [31:0] track_total;

  task automatic add_byte(input logic [7:0] b);
    track_byte_t e;
    track_total = track_total + 32'd1;
    e.value = b;
    e.last  = 1'b0;
    e.total = track_total;
    track_q.push_back(e);
  endtask

  // msb group first, continuation bit on all but the final group
  task automatic add_vlq(input logic [27:0] v);
    int groups;
    int g;
    groups = 1;
    while (groups < 4 && (v >> (7 * groups)) != 28'd0) groups++;
    for (g = groups - 1; g >= 0; g--) add_byte({g != 0, v[7*g +: 7]});
  endtask

  task automatic add_delta(input logic [47:0] t);
    logic [47:0] ms;
    ms = '0;
    // first event of a track and a backward step both give zero
    if (track_total != 32'd0 && t >= stamp) begin
      ms = (t - stamp) / 48'd1000;
      if (ms > 48'(VLQ_MAX)) ms = 48'(VLQ_MAX);
    end
    stamp = t;
    add_vlq(ms[27:0]);
  endtask

  task automatic predict_request();
    int prior_n;
    track_byte_t e;
    prior_n = track_q.size();
    case (in_cmd)
      CMD_SHORT: begin
        add_delta(in_time_us);
        add_byte(in_status);
        if (in_count >= 16'd1) add_byte(in_data_first);
        if (in_count >= 16'd2) add_byte(in_data_second);
      end
      CMD_SYSEX: begin
        add_delta(in_time_us);
        add_byte(SYSEX_ESC);
        add_vlq(28'(in_count));
      end
      CMD_META: begin
        add_delta(in_time_us);
        add_byte(META_MARK);
        add_byte(in_data_first);
        add_vlq(28'(in_count));
      end
      CMD_PAYLOAD: add_byte(in_payload_byte);
      CMD_NEWTRACK: begin
        track_total = '0;
        stamp       = '0;
      end
      default: ;
    endcase
    if (track_q.size() > prior_n) begin
      e = track_q.pop_back();
      e.last = 1'b1;
      track_q.push_back(e);
    end
  endtask

  task automatic check_byte();
    track_byte_t e;
    if (track_q.size() == 0) begin
      $display("%0t: unexpected byte %h last %b track_bytes %0d", $time, out_byte, out_last,
               out_track_bytes);
      errors++;
    end else begin
      e = track_q.pop_front();
      if (out_byte !== e.value) begin
        $display("%0t: out_byte expected %h actual %h", $time, e.value, out_byte);
        errors++;
      end
      if (out_last !== e.last) begin
        $display("%0t: out_last expected %b actual %b", $time, e.last, out_last);
        errors++;
      end
      if (out_track_bytes !== e.total) begin
        $display("%0t: out_track_bytes expected %0d actual %0d", $time, e.total,
                 out_track_bytes);
        errors++;
      end
    end
  endtask

  // output first: a byte leaving this edge can't come from a request taken at it
  always @(posedge clk) begin
    if (!rst_n) begin
      track_q.delete();
      stamp       = '0;
      track_total = '0;
      errors      = 0;
    end else begin
      if (out_valid && !out_stall) check_byte();
      if (in_valid && !in_stall) predict_request();
    end
    pending = track_q.size();
  end

endmodule

// ----- tb/sv/tb_midi_track_event_encoder.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_midi_track_event_encoder
// Drives directed and random MIDI event requests into the track encoder
// with random gaps and output stalls; the checker beside the block predicts
// and compares every track byte, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_midi_track_event_encoder;
  import mtee_pkg::*;

  localparam int         ITEM_TARGET  = 410;
  localparam int         IDLE_LIMIT   = 3000;
  localparam int         DRAIN_CYCLES = 30;
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_cmd;
  logic [47:0] in_time_us;
  logic [7:0]  in_status;
  logic [7:0]  in_data_first;
  logic [7:0]  in_data_second;
  logic [15:0] in_count;
  logic [7:0]  in_payload_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        out_last;
  logic [31:0] out_track_bytes;

  int   mismatches;
  int   pending_bytes;
  int   items_sent = 0;
  int   idle_cycles = 0;
  logic calm = 1'b0;
  int   stall_left = 0;
  logic stall_hold;

  midi_track_event_encoder u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_time_us      (in_time_us),
    .in_status       (in_status),
    .in_data_first   (in_data_first),
    .in_data_second  (in_data_second),
    .in_count        (in_count),
    .in_payload_byte (in_payload_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last        (out_last),
    .out_track_bytes (out_track_bytes)
  );

  mtee_track_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_time_us      (in_time_us),
    .in_status       (in_status),
    .in_data_first   (in_data_first),
    .in_data_second  (in_data_second),
    .in_count        (in_count),
    .in_payload_byte (in_payload_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last        (out_last),
    .out_track_bytes (out_track_bytes),
    .errors          (mismatches),
    .pending         (pending_bytes)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short, now and then long
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [47:0] rand_time();
    return {16'($urandom), $urandom};
  endfunction

  function automatic logic [47:0] step_time(input logic [47:0] t);
    int r;
    logic [47:0] d;
    r = $urandom_range(0, 99);
    if (r < 55) d = 48'($urandom_range(0, 127999));
    else if (r < 75) d = 48'($urandom_range(128000, 16383999));
    else if (r < 85) d = 48'($urandom_range(16384000, 32'hFFFF_FFFF));
    else if (r < 90) d = rand_time();
    else if (r < 95) return t - 48'($urandom_range(0, 5000000));
    else return rand_time();
    return t + d;
  endfunction

  // receiver stalls in runs
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      stall_hold = !calm && ($urandom_range(0, 99) < 35);
      stall_left = stall_hold ? pick_len() - 1 : $urandom_range(0, 8);
      out_stall <= stall_hold;
    end
  end

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("midi_track_event_encoder: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_req(input logic [2:0] cmd, input logic [47:0] t, input logic [7:0] st,
                          input logic [7:0] d1, input logic [7:0] d2, input logic [15:0] cnt,
                          input logic [7:0] pb);
    int gap;
    gap = (calm || $urandom_range(0, 99) < 55) ? 0 : pick_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_cmd          <= cmd;
    in_time_us      <= t;
    in_status       <= st;
    in_data_first   <= d1;
    in_data_second  <= d2;
    in_count        <= cnt;
    in_payload_byte <= pb;
    in_valid        <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_bytes != 0) @(negedge clk);
  endtask

  initial begin
    logic [47:0] now;
    int r;
    int n;
    int next_phase;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_cmd          = CMD_SHORT;
    in_time_us      = '0;
    in_status       = '0;
    in_data_first   = '0;
    in_data_second  = '0;
    in_count        = '0;
    in_payload_byte = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // delta sizes, data byte counts and saturation
    now = 48'd1234567;
    send_req(CMD_SHORT, now, 8'h90, 8'h3C, 8'h7F, 16'd2, 8'h00);  // first of track
    now += 48'd127999;
    send_req(CMD_SHORT, now, 8'hFF, 8'h00, 8'h00, 16'd0, 8'hFF);
    now += 48'd128000;
    send_req(CMD_SHORT, now, 8'h00, 8'hFF, 8'h00, 16'd1, 8'h00);
    now += 48'd16384000;
    send_req(CMD_SHORT, now, 8'hB0, 8'h00, 8'hFF, 16'd3, 8'h00);
    now += 48'd2097152000;
    send_req(CMD_SHORT, now, 8'hC5, 8'hAA, 8'h55, 16'hFFFF, 8'h00);
    now += 48'd268435455999;  // largest delta that still fits
    send_req(CMD_SHORT, now, 8'h80, 8'h40, 8'h01, 16'd2, 8'h00);
    now += 48'd268435456000;  // one past, saturates
    send_req(CMD_SHORT, now, 8'hE0, 8'h7F, 8'h7F, 16'd2, 8'h00);
    send_req(CMD_SHORT, 48'd5, 8'h91, 8'h01, 8'h02, 16'd2, 8'h00);  // time going backward
    send_req(CMD_SHORT, 48'd5, 8'h92, 8'h03, 8'h04, 16'd1, 8'h00);  // same time
    now = 48'hFFFF_FFFF_FFFF;
    send_req(CMD_SHORT, now, 8'hF8, 8'h00, 8'h00, 16'd0, 8'h00);
    send_req(CMD_SYSEX, now, 8'h00, 8'h00, 8'h00, 16'd0, 8'h00);
    send_req(CMD_SYSEX, now, 8'h00, 8'h00, 8'h00, 16'd127, 8'h00);
    send_req(CMD_PAYLOAD, now, 8'h00, 8'h00, 8'h00, 16'd0, 8'h00);
    send_req(CMD_PAYLOAD, now, 8'h00, 8'h00, 8'h00, 16'd0, 8'hFF);
    send_req(CMD_SYSEX, now, 8'h00, 8'h00, 8'h00, 16'd128, 8'h00);
    send_req(CMD_SYSEX, now, 8'h00, 8'h00, 8'h00, 16'hFFFF, 8'h00);
    send_req(CMD_META, now, 8'h00, 8'hFF, 8'h00, 16'd0, 8'h00);
    send_req(CMD_META, now, 8'h00, 8'h00, 8'h00, 16'd16384, 8'h00);
    for (n = CMD_UNUSED_LO; n <= CMD_UNUSED_HI; n++)
      send_req(3'(n), rand_time(), 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
               8'($urandom));
    // payload before any event: the next delta counts from time zero
    send_req(CMD_NEWTRACK, rand_time(), 8'h00, 8'h00, 8'h00, 16'd0, 8'h00);
    send_req(CMD_PAYLOAD, now, 8'h00, 8'h00, 8'h00, 16'd0, 8'h5A);
    now = 48'h0000_1000_0000;
    send_req(CMD_SHORT, now, 8'h90, 8'h40, 8'h64, 16'd2, 8'h00);
    send_req(CMD_NEWTRACK, rand_time(), 8'h00, 8'h00, 8'h00, 16'd0, 8'h00);
    now = 48'h8000_0000_0000;
    send_req(CMD_META, now, 8'h00, 8'h51, 8'h00, 16'd3, 8'h00);

    wait_drained();

    next_phase = items_sent;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= next_phase) begin
        next_phase += 60;
        calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 1) == 0) wait_drained();
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
        now = step_time(now);
        send_req(CMD_SHORT, now, 8'($urandom), 8'($urandom), 8'($urandom),
                 ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2)),
                 8'($urandom));
      end else if (r < 83) begin
        // well-formed sysex or meta with its payload
        n = $urandom_range(0, 5);
        now = step_time(now);
        send_req((r < 70) ? CMD_SYSEX : CMD_META, now, 8'($urandom), 8'($urandom),
                 8'($urandom), 16'(n), 8'($urandom));
        repeat (n)
          send_req(CMD_PAYLOAD, rand_time(), 8'($urandom), 8'($urandom), 8'($urandom),
                   16'($urandom), 8'($urandom));
      end else if (r < 87) begin
        send_req(CMD_NEWTRACK, rand_time(), 8'($urandom), 8'($urandom), 8'($urandom),
                 16'($urandom), 8'($urandom));
      end else if (r < 91) begin
        send_req(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), rand_time(), 8'($urandom),
                 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
      end else if (r < 95) begin
        send_req(CMD_PAYLOAD, rand_time(), 8'($urandom), 8'($urandom), 8'($urandom),
                 16'($urandom), 8'($urandom));
      end else begin
        // broken sequence: large length, no payload follows
        now = step_time(now);
        send_req((r < 98) ? CMD_SYSEX : CMD_META, now, 8'($urandom), 8'($urandom),
                 8'($urandom), 16'($urandom), 8'($urandom));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("midi_track_event_encoder: match");
    end else begin
      $display("midi_track_event_encoder: mismatch");
    end
    $finish;
  end

endmodule
